@@ rtl/cov_pkg.sv @@
`default_nettype none
package cov_pkg;

  // Row limits and fixed point format
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned FRAC_BITS   = 8;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned SUM_W    = 36;
  localparam int unsigned SQ_W     = 60;
  localparam int unsigned CV_W     = 32;
  localparam int unsigned SCALE_W  = 15;

  // 100 percent in Q.FRAC_BITS
  localparam logic [SCALE_W-1:0] CV_SCALE = SCALE_W'(100 << FRAC_BITS);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(MAX_SAMPLES);
  localparam logic [COUNT_W-1:0] COUNT_OVER = COUNT_W'(MAX_SAMPLES + 1);

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } cov_in_t;

  typedef struct packed {
    logic signed [CV_W-1:0] cv_percent;
    logic [1:0]             status;
  } cov_out_t;

  // Totals of one finished row
  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic signed [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]          sq;
  } cov_row_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_NQ,
    BK_MUL_SS,
    BK_DIFF,
    BK_DIV_V,
    BK_SQRT,
    BK_SCALE1,
    BK_SCALE2,
    BK_DIV_Q,
    BK_FINISH
  } bk_state_t;

endpackage
`default_nettype wire

@@ rtl/cov_front.sv @@
`default_nettype none
module cov_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cov_pkg::cov_in_t in_req,
  output logic                  row_valid,
  input  wire logic             row_ready,
  output cov_pkg::cov_row_t     row
);

  logic                                   pend_valid;
  logic signed [cov_pkg::SAMPLE_W-1:0]    pend_x;
  logic                                   pend_last;
  logic [cov_pkg::COUNT_W-1:0]            count;
  logic signed [cov_pkg::SUM_W-1:0]       sum;
  logic [cov_pkg::SQ_W-1:0]               sq;
  logic [cov_pkg::COUNT_W-1:0]            count_next;
  logic signed [cov_pkg::SUM_W-1:0]       sum_next;
  logic [cov_pkg::SQ_W-1:0]               sq_next;
  logic [cov_pkg::SAMPLE_W-1:0]           ax;
  logic [2*cov_pkg::SAMPLE_W-1:0]         ax_sq;
  logic                                   step;

  // A held sample is folded in unless it ends a row and the queue is full
  assign step     = pend_valid && (!pend_last || row_ready);
  assign in_ready = !pend_valid || step;

  assign ax = pend_x[cov_pkg::SAMPLE_W-1] ? cov_pkg::SAMPLE_W'(-pend_x)
                                          : cov_pkg::SAMPLE_W'(pend_x);
  assign ax_sq = ax * ax;

  // Accumulate, samples past the limit are dropped
  always_comb begin
    if (count < cov_pkg::COUNT_MAX) begin
      count_next = count + 1'b1;
      sum_next   = sum + cov_pkg::SUM_W'(pend_x);
      sq_next    = sq + cov_pkg::SQ_W'(ax_sq);
    end else begin
      count_next = cov_pkg::COUNT_OVER;
      sum_next   = sum;
      sq_next    = sq;
    end
  end

  assign row_valid = pend_valid && pend_last;
  assign row.count = count_next;
  assign row.sum   = sum_next;
  assign row.sq    = sq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      count      <= '0;
      sum        <= '0;
      sq         <= '0;
    end else begin
      if (in_ready) begin
        pend_valid <= in_valid;
      end
      if (step) begin
        if (pend_last) begin
          count <= '0;
          sum   <= '0;
          sq    <= '0;
        end else begin
          count <= count_next;
          sum   <= sum_next;
          sq    <= sq_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pend_x    <= in_req.sample;
      pend_last <= in_req.last_sample;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cov_queue.sv @@
`default_nettype none
module cov_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire cov_pkg::cov_row_t wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output cov_pkg::cov_row_t      rd_data
);

  cov_pkg::cov_row_t entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;
  logic              pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cov_back.sv @@
`default_nettype none
module cov_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              row_valid,
  output logic                   row_ready,
  input  wire cov_pkg::cov_row_t row,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cov_pkg::cov_out_t      out_req
);

  localparam int unsigned WIDE_W = 74;
  localparam int unsigned REM_W  = 37;

  cov_pkg::bk_state_t state, state_next;

  logic [cov_pkg::COUNT_W-1:0] n_r;
  logic                        dropped_r;
  logic                        neg_r;
  logic [cov_pkg::SUM_W-1:0]   mag_r;
  logic                        spec_r;
  logic [1:0]                  spec_st;
  logic [WIDE_W-1:0]           acc;
  logic [WIDE_W-1:0]           mcand;
  logic [cov_pkg::SUM_W-1:0]   mult;
  logic [WIDE_W-1:0]           nq_r;
  logic [6:0]                  cnt;
  logic [WIDE_W-1:0]           dv;
  logic [REM_W-1:0]            rem;
  logic [cov_pkg::SUM_W-1:0]   dvsr;
  logic [63:0]                 sv;
  logic [63:0]                 sres;
  logic [63:0]                 sbit;
  logic [44:0]                 p_r;

  // Incoming row decode
  logic                        in_drop;
  logic [cov_pkg::COUNT_W-1:0] in_n;
  logic [cov_pkg::SUM_W-1:0]   in_mag;
  logic                        pop;
  logic                        last_step;

  // Step datapaths
  logic [WIDE_W-1:0]           acc_step;
  logic [REM_W-1:0]            rem_sh;
  logic                        div_ge;
  logic [REM_W-1:0]            rem_step;
  logic [WIDE_W-1:0]           dv_step;
  logic [63:0]                 sq_try;
  logic [25:0]                 nn1;
  logic [44:0]                 sd_n;
  logic [59:0]                 p_scaled;
  logic [63:0]                 q;
  logic [cov_pkg::CV_W-1:0]    cv_fin;
  logic [1:0]                  st_fin;
  logic                        out_free;

  assign in_drop = (row.count == cov_pkg::COUNT_OVER);
  assign in_n    = in_drop ? cov_pkg::COUNT_MAX : row.count;
  assign in_mag  = row.sum[cov_pkg::SUM_W-1] ? cov_pkg::SUM_W'(-row.sum)
                                             : cov_pkg::SUM_W'(row.sum);
  assign last_step = (cnt == 7'd1);
  assign out_free  = !out_valid || out_ready;

  // Shift-add multiply step
  assign acc_step = mult[0] ? acc + mcand : acc;

  // Restoring divide step
  assign rem_sh   = {rem[REM_W-2:0], dv[WIDE_W-1]};
  assign div_ge   = rem_sh >= REM_W'(dvsr);
  assign rem_step = div_ge ? rem_sh - REM_W'(dvsr) : rem_sh;
  assign dv_step  = {dv[WIDE_W-2:0], div_ge};

  assign sq_try = sres + sbit;
  assign nn1    = n_r * (n_r - 1'b1);

  // Scale products: sd * n, then times 100 in Q.FRAC_BITS
  assign sd_n     = sres[31:0] * n_r;
  assign p_scaled = p_r * cov_pkg::CV_SCALE;

  // Final sign, clamp and status
  always_comb begin
    q      = dv[63:0];
    st_fin = dropped_r ? cov_pkg::ST_SAT : cov_pkg::ST_OK;
    if (spec_r) begin
      cv_fin = '0;
      st_fin = spec_st;
    end else if (!neg_r) begin
      if (q > 64'h7FFF_FFFF) begin
        cv_fin = 32'h7FFF_FFFF;
        st_fin = cov_pkg::ST_SAT;
      end else begin
        cv_fin = q[31:0];
      end
    end else begin
      if (q > 64'h8000_0000) begin
        cv_fin = 32'h8000_0000;
        st_fin = cov_pkg::ST_SAT;
      end else begin
        cv_fin = -q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cov_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      cov_pkg::BK_IDLE: begin
        if (row_valid) begin
          pop = 1'b1;
          if (in_n < 13'd2 || in_mag == '0) begin
            state_next = cov_pkg::BK_FINISH;
          end else begin
            state_next = cov_pkg::BK_MUL_NQ;
          end
        end
      end
      cov_pkg::BK_MUL_NQ: if (last_step) state_next = cov_pkg::BK_MUL_SS;
      cov_pkg::BK_MUL_SS: if (last_step) state_next = cov_pkg::BK_DIFF;
      cov_pkg::BK_DIFF:   state_next = cov_pkg::BK_DIV_V;
      cov_pkg::BK_DIV_V:  if (last_step) state_next = cov_pkg::BK_SQRT;
      cov_pkg::BK_SQRT:   if (last_step) state_next = cov_pkg::BK_SCALE1;
      cov_pkg::BK_SCALE1: state_next = cov_pkg::BK_SCALE2;
      cov_pkg::BK_SCALE2: state_next = cov_pkg::BK_DIV_Q;
      cov_pkg::BK_DIV_Q:  if (last_step) state_next = cov_pkg::BK_FINISH;
      cov_pkg::BK_FINISH: if (out_free) state_next = cov_pkg::BK_IDLE;
      default:            state_next = cov_pkg::BK_IDLE;
    endcase
  end

  assign row_ready = pop;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cov_pkg::BK_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cov_pkg::BK_FINISH && out_free) begin
      out_req.cv_percent <= cv_fin;
      out_req.status     <= st_fin;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      cov_pkg::BK_IDLE: begin
        n_r       <= in_n;
        dropped_r <= in_drop;
        neg_r     <= row.sum[cov_pkg::SUM_W-1];
        mag_r     <= in_mag;
        spec_r    <= (in_n < 13'd2) || (in_mag == '0);
        spec_st   <= (in_n < 13'd2) ? cov_pkg::ST_FEW : cov_pkg::ST_ZERO;
        acc       <= '0;
        mcand     <= WIDE_W'(row.sq);
        mult      <= cov_pkg::SUM_W'(in_n);
        cnt       <= 7'(cov_pkg::COUNT_W);
      end
      cov_pkg::BK_MUL_NQ: begin
        if (last_step) begin
          nq_r  <= acc_step;
          acc   <= '0;
          mcand <= WIDE_W'(mag_r);
          mult  <= mag_r;
          cnt   <= 7'(cov_pkg::SUM_W);
        end else begin
          acc   <= acc_step;
          mcand <= {mcand[WIDE_W-2:0], 1'b0};
          mult  <= mult >> 1;
          cnt   <= cnt - 1'b1;
        end
      end
      cov_pkg::BK_MUL_SS: begin
        acc   <= acc_step;
        mcand <= {mcand[WIDE_W-2:0], 1'b0};
        mult  <= mult >> 1;
        cnt   <= cnt - 1'b1;
      end
      cov_pkg::BK_DIFF: begin
        dv   <= (nq_r >= acc) ? nq_r - acc : '0;
        rem  <= '0;
        dvsr <= cov_pkg::SUM_W'(nn1);
        cnt  <= 7'(WIDE_W);
      end
      cov_pkg::BK_DIV_V: begin
        if (last_step) begin
          sv   <= dv_step[63:0];
          sres <= '0;
          sbit <= 64'd1 << 62;
          cnt  <= 7'd32;
        end else begin
          dv  <= dv_step;
          rem <= rem_step;
          cnt <= cnt - 1'b1;
        end
      end
      cov_pkg::BK_SQRT: begin
        if (sv >= sq_try) begin
          sv   <= sv - sq_try;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
        cnt  <= cnt - 1'b1;
      end
      cov_pkg::BK_SCALE1: begin
        p_r <= sd_n;
      end
      cov_pkg::BK_SCALE2: begin
        dv   <= {4'b0, p_scaled, 10'b0};
        rem  <= '0;
        dvsr <= mag_r;
        cnt  <= 7'd64;
      end
      cov_pkg::BK_DIV_Q: begin
        dv  <= dv_step;
        rem <= rem_step;
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/coefficient_of_variation.sv @@
`default_nettype none
// Coefficient of variation of a row of Q.8 samples, in percent (Q.8, signed,
// saturated). The front end folds one sample per cycle, unless a row ends
// with the queue full, into count, sum and sum of squares; at the last sample
// of a row the totals go into a two-deep queue and the next row can start at
// once. The back end works one row at a time with shift-add multiplies and
// bit-serial divide and square root (13 + 36 multiply steps, 74 + 64 divide
// steps, 32 root steps); rows with fewer than two samples or a zero sum skip
// to the finish. Samples past 4096 per row are dropped and flag saturation.
module coefficient_of_variation (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cov_pkg::cov_in_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cov_pkg::cov_out_t      out_req
);

  logic              f_valid;
  logic              f_ready;
  cov_pkg::cov_row_t f_row;
  logic              b_valid;
  logic              b_ready;
  cov_pkg::cov_row_t b_row;

  cov_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .row_valid (f_valid),
    .row_ready (f_ready),
    .row       (f_row)
  );

  cov_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_row),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_row)
  );

  cov_back u_back (
    .clk       (clk),
    .rst       (rst),
    .row_valid (b_valid),
    .row_ready (b_ready),
    .row       (b_row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

endmodule
`default_nettype wire
